[src/smu_pkg.sv]
// Shared types, widths and exponential tables for the softmax unit.
// Depends on nothing; used by the front, back and top-level modules.
`default_nettype none
package smu_pkg;

    localparam int SCORE_W   = 16;
    localparam int PROB_W    = 16;
    localparam int POS_W     = 6;
    localparam int EXP_W     = 17;
    localparam int SUM_W     = 23;
    localparam int JOB_CNT_W = 7;
    localparam int DEF_MAX_LEN = 32;

    typedef struct packed {
        logic [JOB_CNT_W-1:0]      cnt;
        logic signed [SCORE_W-1:0] max_score;
        logic                      ovf;
    } t_job;

    function automatic logic [16:0] exp_int(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd24109;
            5'd2:    v = 17'd8869;
            5'd3:    v = 17'd3263;
            5'd4:    v = 17'd1200;
            5'd5:    v = 17'd442;
            5'd6:    v = 17'd162;
            5'd7:    v = 17'd60;
            5'd8:    v = 17'd22;
            5'd9:    v = 17'd8;
            5'd10:   v = 17'd3;
            5'd11:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] h);
        logic [16:0] v;
        case (h)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd61565;
            4'd2:    v = 17'd57835;
            4'd3:    v = 17'd54331;
            4'd4:    v = 17'd51039;
            4'd5:    v = 17'd47947;
            4'd6:    v = 17'd45042;
            4'd7:    v = 17'd42313;
            4'd8:    v = 17'd39750;
            4'd9:    v = 17'd37341;
            4'd10:   v = 17'd35079;
            4'd11:   v = 17'd32954;
            4'd12:   v = 17'd30957;
            4'd13:   v = 17'd29081;
            4'd14:   v = 17'd27319;
            default: v = 17'd25664;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] l);
        logic [16:0] v;
        case (l)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd65280;
            4'd2:    v = 17'd65026;
            4'd3:    v = 17'd64772;
            4'd4:    v = 17'd64520;
            4'd5:    v = 17'd64268;
            4'd6:    v = 17'd64018;
            4'd7:    v = 17'd63768;
            4'd8:    v = 17'd63520;
            4'd9:    v = 17'd63272;
            4'd10:   v = 17'd63025;
            4'd11:   v = 17'd62780;
            4'd12:   v = 17'd62535;
            4'd13:   v = 17'd62291;
            4'd14:   v = 17'd62048;
            default: v = 17'd61806;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[src/smu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module smu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[src/smu_front.sv]
// Input side: stores scores, tracks maximum, count and overflow, and hands a job to the back.
// Depends on smu_pkg and smu_ram.
`default_nettype none
module smu_front #(
    parameter int MAX_LEN = smu_pkg::DEF_MAX_LEN
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    output logic                              o_full,
    input  wire logic signed [smu_pkg::SCORE_W-1:0] i_score,
    input  wire logic                         i_last_element,
    input  wire logic                         i_back_busy,
    input  wire logic                         i_take,
    output logic                              o_job_valid,
    output smu_pkg::t_job                     o_job,
    input  wire logic [$clog2(MAX_LEN)-1:0]   i_raddr,
    output logic [smu_pkg::SCORE_W-1:0]       o_rdata
);
    import smu_pkg::*;
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0]             r_cnt, n_cnt;
    logic signed [SCORE_W-1:0] r_max, n_max;
    logic                      r_ovf, n_ovf;
    logic                      r_job_valid;
    t_job                      r_job;
    logic                      w_accept, w_store;

    assign o_full      = r_job_valid | i_back_busy;
    assign w_accept    = i_push & ~o_full;
    assign w_store     = w_accept & (r_cnt < CW'(MAX_LEN));
    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_comb begin
        n_cnt = r_cnt;
        n_max = r_max;
        n_ovf = r_ovf;
        if (w_store) begin
            n_cnt = r_cnt + CW'(1);
            if (i_score > r_max) begin
                n_max = i_score;
            end
        end else if (w_accept) begin
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_max       <= {1'b1, {(SCORE_W-1){1'b0}}};
            r_ovf       <= 1'b0;
            r_job_valid <= 1'b0;
        end else begin
            if (i_take) begin
                r_job_valid <= 1'b0;
            end
            if (w_accept && i_last_element) begin
                r_job_valid <= 1'b1;
                r_job.cnt   <= JOB_CNT_W'(n_cnt);
                r_job.max_score <= n_max;
                r_job.ovf   <= n_ovf;
                r_cnt       <= '0;
                r_max       <= {1'b1, {(SCORE_W-1){1'b0}}};
                r_ovf       <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_max <= n_max;
                r_ovf <= n_ovf;
            end
        end
    end

    smu_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_LEN)) u_score_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_score),
        .i_raddr (i_raddr),
        .o_rdata (o_rdata)
    );
endmodule
`default_nettype wire

[src/smu_back.sv]
// Processing side: exponential pass with running sum, then a divide pass emitting results.
// Depends on smu_pkg and smu_ram.
`default_nettype none
module smu_back #(
    parameter int MAX_LEN = smu_pkg::DEF_MAX_LEN
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  smu_pkg::t_job                     i_job,
    output logic                              o_take,
    output logic                              o_busy,
    output logic [$clog2(MAX_LEN)-1:0]        o_raddr,
    input  wire logic [smu_pkg::SCORE_W-1:0]  i_rdata,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [smu_pkg::PROB_W-1:0]        o_probability,
    output logic [smu_pkg::POS_W-1:0]         o_position,
    output logic                              o_last_result,
    output logic                              o_truncated
);
    import smu_pkg::*;
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXP  = 3'd1;
    localparam logic [2:0] S_DRD  = 3'd2;
    localparam logic [2:0] S_DLD  = 3'd3;
    localparam logic [2:0] S_DIT  = 3'd4;
    localparam logic [2:0] S_DOUT = 3'd5;

    logic [2:0]                r_state;
    logic [CW-1:0]             r_cnt, r_iss;
    logic signed [SCORE_W-1:0] r_max;
    logic                      r_ovf;
    logic [SUM_W-1:0]          r_sum;
    logic                      r_v0, r_va, r_vb;
    logic [AW-1:0]             r_i0, r_ia, r_ib, r_didx;
    logic [33:0]               r_p1;
    logic [33:0]               r_p2;
    logic [3:0]                r_la;
    logic                      r_za, r_zb;
    logic [SUM_W:0]            r_rem;
    logic [17:0]               r_nb, r_q;
    logic [1:0]                r_it;
    logic                      r_out_valid;
    logic [PROB_W-1:0]         r_prob;
    logic [POS_W-1:0]          r_pos;
    logic                      r_olast, r_otrunc;

    logic                      w_issue, w_we;
    logic signed [SCORE_W:0]   w_d;
    logic [SCORE_W:0]          w_n;
    logic [33:0]               w_p1, w_p2;
    logic [16:0]               w_t, w_e;
    logic [EXP_W-1:0]          w_exp_rd;
    logic [AW-1:0]             w_eraddr;
    logic [SUM_W:0]            w_rem;
    logic [17:0]               w_nb, w_q;
    logic                      w_slot;
    logic                      w_emit;

    assign o_busy  = (r_state == S_EXP);
    assign o_take  = (r_state == S_IDLE) & i_job_valid;
    assign w_issue = (r_state == S_EXP) & (r_iss < r_cnt);
    assign o_raddr = r_iss[AW-1:0];
    assign w_slot  = ~r_out_valid | i_pop;
    assign w_emit  = (r_state == S_DOUT) & w_slot;

    always_comb begin
        w_d  = $signed({i_rdata[SCORE_W-1], i_rdata}) - $signed({r_max[SCORE_W-1], r_max});
        w_n  = (SCORE_W+1)'(-w_d);
        w_p1 = 34'(exp_int((w_n[15:12] == 4'd0) ? w_n[12:8] : 5'd31) *
                    exp_hi(w_n[7:4]));
        w_t  = 17'((r_p1 + 34'd32768) >> 16);
        w_p2 = 34'(w_t * exp_lo(r_la));
        w_e  = r_zb ? 17'd0 : 17'((r_p2 + 34'd32768) >> 16);
        w_we = r_vb;
    end

    always_comb begin
        w_rem = r_rem;
        w_nb  = r_nb;
        w_q   = r_q;
        for (int j = 0; j < 6; j++) begin
            w_rem = {w_rem[SUM_W-1:0], w_nb[17]};
            w_nb  = {w_nb[16:0], 1'b0};
            if (w_rem >= {1'b0, r_sum}) begin
                w_rem = w_rem - {1'b0, r_sum};
                w_q   = {w_q[16:0], 1'b1};
            end else begin
                w_q   = {w_q[16:0], 1'b0};
            end
        end
    end

    assign w_eraddr = (r_state == S_EXP) ? r_ib : r_didx;

    always_ff @(posedge i_clk) begin
        r_i0 <= r_iss[AW-1:0];
        r_ia <= r_i0;
        r_ib <= r_ia;
        r_p1 <= w_p1;
        r_la <= w_n[3:0];
        r_za <= (w_n > (SCORE_W+1)'(4096));
        r_p2 <= w_p2;
        r_zb <= r_za;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v0        <= 1'b0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v0 <= w_issue;
            r_va <= r_v0;
            r_vb <= r_va;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_cnt   <= CW'(i_job.cnt);
                        r_max   <= i_job.max_score;
                        r_ovf   <= i_job.ovf;
                        r_iss   <= '0;
                        r_sum   <= '0;
                        r_didx  <= '0;
                        r_state <= S_EXP;
                    end
                end
                S_EXP: begin
                    if (w_issue) begin
                        r_iss <= r_iss + CW'(1);
                    end
                    if (r_vb) begin
                        r_sum <= r_sum + SUM_W'(w_e);
                    end
                    if (!w_issue && !r_v0 && !r_va && !r_vb) begin
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    r_state <= S_DLD;
                end
                S_DLD: begin
                    r_rem   <= (SUM_W+1)'(w_exp_rd[16:2]);
                    r_nb    <= {w_exp_rd[1:0], 16'd0};
                    r_q     <= '0;
                    r_it    <= '0;
                    r_state <= S_DIT;
                end
                S_DIT: begin
                    r_rem <= w_rem;
                    r_nb  <= w_nb;
                    r_q   <= w_q;
                    r_it  <= r_it + 2'd1;
                    if (r_it == 2'd2) begin
                        r_state <= S_DOUT;
                    end
                end
                S_DOUT: begin
                    if (w_slot) begin
                        r_prob   <= (r_sum == '0) ? '0 :
                                    (r_q > 18'd65535) ? 16'hffff : r_q[15:0];
                        r_pos    <= POS_W'(r_didx);
                        r_olast  <= (CW'(r_didx) + CW'(1) == r_cnt);
                        r_otrunc <= r_ovf;
                        r_didx   <= r_didx + AW'(1);
                        r_state  <= (CW'(r_didx) + CW'(1) == r_cnt) ? S_IDLE : S_DRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty       = ~r_out_valid;
    assign o_probability = r_prob;
    assign o_position    = r_pos;
    assign o_last_result = r_olast;
    assign o_truncated   = r_otrunc;

    smu_ram #(.WIDTH(EXP_W), .DEPTH(MAX_LEN)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ib),
        .i_wdata (w_e),
        .i_raddr (w_eraddr),
        .o_rdata (w_exp_rd)
    );
endmodule
`default_nettype wire

[src/softmax_unit_top.sv]
// Top level of the softmax unit: front (loading) and back (exp and divide passes).
// Depends on smu_pkg, smu_front, smu_back and smu_ram.
//
//   Channel   Handshake          Beat contents
//   input     i_push / o_full    i_score, i_last_element
//   result    o_empty / i_pop    o_probability, o_position, o_last_result, o_truncated
//
// Loading takes one element per cycle while o_full is low. After the last element, the exp
// pass streams the N stored elements through the score RAM read and two multiplier stages, and
// the divide pass produces one result at a time (exp RAM read, three 6-bit divider steps).
// Reset is synchronous and clears all control state; the RAMs need no clearing.
// The next vector loads during the divide pass; a held result stalls only the back.
`default_nettype none
module softmax_unit_top #(
    parameter int MAX_LEN = smu_pkg::DEF_MAX_LEN
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_push,
    output logic                                    o_full,
    input  wire logic signed [smu_pkg::SCORE_W-1:0] i_score,
    input  wire logic                               i_last_element,
    input  wire logic                               i_pop,
    output logic                                    o_empty,
    output logic [smu_pkg::PROB_W-1:0]              o_probability,
    output logic [smu_pkg::POS_W-1:0]               o_position,
    output logic                                    o_last_result,
    output logic                                    o_truncated
);
    import smu_pkg::*;

    logic                       w_busy, w_take, w_job_valid;
    t_job                       w_job;
    logic [$clog2(MAX_LEN)-1:0] w_raddr;
    logic [SCORE_W-1:0]         w_rdata;

    smu_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_score        (i_score),
        .i_last_element (i_last_element),
        .i_back_busy    (w_busy),
        .i_take         (w_take),
        .o_job_valid    (w_job_valid),
        .o_job          (w_job),
        .i_raddr        (w_raddr),
        .o_rdata        (w_rdata)
    );

    smu_back #(.MAX_LEN(MAX_LEN)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_take        (w_take),
        .o_busy        (w_busy),
        .o_raddr       (w_raddr),
        .i_rdata       (w_rdata),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_probability (o_probability),
        .o_position    (o_position),
        .o_last_result (o_last_result),
        .o_truncated   (o_truncated)
    );
endmodule
`default_nettype wire

[tb/softmax_unit_checker.sv]
// Checker for the softmax unit: watches the score and probability channels,
// predicts each vector's probabilities and compares them beat by beat.
// Depends on smu_pkg for the port widths.
module softmax_unit_checker #(
    parameter int MAX_LEN = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic signed [smu_pkg::SCORE_W-1:0] i_score,
    input  logic                               i_last_element,
    input  logic                               i_pop,
    input  logic                               i_empty,
    input  logic [smu_pkg::PROB_W-1:0]         i_probability,
    input  logic [smu_pkg::POS_W-1:0]          i_position,
    input  logic                               i_last_result,
    input  logic                               i_truncated,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] prob;
        logic [5:0]  pos;
        logic        last;
        logic        trunc;
    } t_prob_beat;

    localparam int INT_TAB [17] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22,
                                    8, 3, 1, 0, 0, 0, 0, 0};
    localparam int HI_TAB [16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042,
                                   42313, 39750, 37341, 35079, 32954, 30957, 29081,
                                   27319, 25664};
    localparam int LO_TAB [16] = '{65536, 65280, 65026, 64772, 64520, 64268, 64018,
                                   63768, 63520, 63272, 63025, 62780, 62535, 62291,
                                   62048, 61806};

    t_prob_beat  prob_q[$];
    logic signed [15:0] vec_scores[$];
    int          vec_max;
    logic        vec_dropped;

    assign o_pending = prob_q.size();

    function automatic longint fixed_exp(int diff);
        int     n;
        longint t;
        n = (diff > 0) ? 0 : -diff;
        if (n > 4096) return 0;
        t = (longint'(INT_TAB[n >> 8]) * HI_TAB[(n >> 4) & 15] + 32768) >> 16;
        return (t * LO_TAB[n & 15] + 32768) >> 16;
    endfunction

    task automatic predict_vector();
        longint    exps[$];
        longint    total;
        longint    p;
        t_prob_beat b;
        total = 0;
        foreach (vec_scores[i]) begin
            exps.push_back(fixed_exp(int'(vec_scores[i]) - vec_max));
            total = (total + exps[i]) & 64'h7FFFFF;
        end
        foreach (exps[i]) begin
            p = (total != 0) ? (exps[i] << 16) / total : 0;
            if (p > 65535) p = 65535;
            b.prob  = p[15:0];
            b.pos   = i[5:0];
            b.last  = (i == exps.size() - 1);
            b.trunc = vec_dropped;
            prob_q.push_back(b);
        end
        vec_scores.delete();
        vec_max     = -32768;
        vec_dropped = 1'b0;
    endtask

    initial begin
        o_errors    = 0;
        o_results   = 0;
        vec_max     = -32768;
        vec_dropped = 1'b0;
    end

    always @(posedge i_clk) begin
        t_prob_beat want;
        if (i_rst_n && i_push && !i_full) begin
            if (vec_scores.size() < MAX_LEN) begin
                vec_scores.push_back(i_score);
                if (int'(i_score) > vec_max) vec_max = int'(i_score);
            end else begin
                vec_dropped = 1'b1;
            end
            if (i_last_element) predict_vector();
        end
        if (i_rst_n && i_pop && !i_empty) begin
            o_results++;
            if (prob_q.size() == 0) begin
                $error("probability beat with nothing expected");
                o_errors++;
            end else begin
                want = prob_q.pop_front();
                if (i_probability !== want.prob) begin
                    $error("probability: expected %0d, got %0d", want.prob, i_probability);
                    o_errors++;
                end
                if (i_position !== want.pos) begin
                    $error("position: expected %0d, got %0d", want.pos, i_position);
                    o_errors++;
                end
                if (i_last_result !== want.last) begin
                    $error("last_result: expected %0b, got %0b", want.last, i_last_result);
                    o_errors++;
                end
                if (i_truncated !== want.trunc) begin
                    $error("truncated: expected %0b, got %0b", want.trunc, i_truncated);
                    o_errors++;
                end
            end
        end
    end
endmodule

[tb/softmax_unit_top_tb.sv]
// Testbench top for the softmax unit: drives score vectors through the push side,
// pops probabilities under several idling phases and gives the verdict.
// Depends on smu_pkg, softmax_unit_top and softmax_unit_checker.
module softmax_unit_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN = 32;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic signed [15:0] score = '0;
    logic        last_el = 1'b0;
    logic        pop = 1'b0;
    logic        empty;
    logic [15:0] prob;
    logic [5:0]  pos;
    logic        last_res;
    logic        trunc;
    int          errors;
    int          pending;
    int          results;
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          cycles = 0;
    int          beats_sent = 0;
    int          vectors_sent = 0;

    always #4 clk = ~clk;

    softmax_unit_top #(.MAX_LEN(MAX_LEN)) u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .o_full(full),
        .i_score(score), .i_last_element(last_el), .i_pop(pop), .o_empty(empty),
        .o_probability(prob), .o_position(pos), .o_last_result(last_res),
        .o_truncated(trunc)
    );

    softmax_unit_checker #(.MAX_LEN(MAX_LEN)) u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_push(push), .i_full(full), .i_score(score),
        .i_last_element(last_el), .i_pop(pop), .i_empty(empty), .i_probability(prob),
        .i_position(pos), .i_last_result(last_res), .i_truncated(trunc),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        pop    <= ($urandom_range(99) >= pop_stall_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_score(input logic [15:0] s, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        score   <= s;
        last_el <= lst;
        @(posedge clk);
        while (full) @(posedge clk);
        beats_sent++;
        if (lst) vectors_sent++;
    endtask

    task automatic send_vector(input int len, input int spread, input int center);
        int v;
        for (int i = 0; i < len; i++) begin
            v = center + $signed($urandom_range(2 * spread)) - spread;
            if ($urandom_range(15) == 0) v = $urandom;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_score(v[15:0], i == len - 1);
        end
    endtask

    initial begin
        int len;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_score(16'h7FFF, 1'b1);
        send_score(16'h8000, 1'b0);
        send_score(16'h7FFF, 1'b1);
        send_score(16'h8000, 1'b0);
        send_score(16'h8000, 1'b1);
        send_score(16'h0000, 1'b0);
        send_score(16'hF000, 1'b0);
        send_score(16'hEFFF, 1'b0);
        send_score(16'hFFFF, 1'b0);
        send_score(16'h5555, 1'b0);
        send_score(16'hAAAA, 1'b1);
        for (int i = 0; i < MAX_LEN + 3; i++) begin
            send_score(16'(16'h0100 * (i % 3)), i == MAX_LEN + 2);
        end
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 52 : 16) : 0;
            pop_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 52 : 16) : 0;
            repeat (6) begin
                case ($urandom_range(9))
                    0:       len = MAX_LEN + $urandom_range(4);
                    1:       len = 1;
                    default: len = $urandom_range(2, 10);
                endcase
                send_vector(len, $urandom_range(1) ? 3000 : 400,
                            $signed($urandom_range(40000)) - 20000);
            end
        end
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d scores in %0d vectors, checked %0d probabilities.",
                 beats_sent, vectors_sent, results);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
